// File: hw/rtl/emst_pkg.sv
`timescale 1ns / 1ps
package emst_pkg;

  localparam int unsigned MaxPointsDefault = 64;
  localparam int unsigned CoordW = 16;
  localparam int unsigned LenW = 39;
  localparam int unsigned CountW = 7;
  localparam int unsigned D2W = 33;
  localparam int unsigned RootW = 34;
  localparam int unsigned DistW = 35;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_RD,
    ST_DIFF,
    ST_SQ,
    ST_ROOT,
    ST_UPD,
    ST_PICK,
    ST_OUT
  } emst_state_t;

  // controller to datapath
  typedef struct packed {
    logic store_pt;
    logic clr_set;
    logic init_row;
    logic read_pair;
    logic take_diff;
    logic take_sq;
    logic root_start;
    logic root_step;
    logic update;
    logic pick;
    logic load_result;
  } emst_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic few;
    logic root_done;
    logic row_last;
    logic init_last;
    logic tree_done;
  } emst_sts_t;

endpackage

// File: hw/rtl/emst_ctrl.sv
`timescale 1ns / 1ps
module emst_ctrl
  import emst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic        in_last,
  input  logic        out_free,
  input  emst_sts_t   sts,
  output emst_cmd_t   cmd,
  output logic        in_ready,
  output logic        res_load
);

  emst_state_t state_r, state_nxt;

  // advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: if (in_fire && in_last) state_nxt = ST_INIT;
      ST_INIT: begin
        if (sts.few) state_nxt = ST_OUT;
        else if (sts.init_last) state_nxt = ST_RD;
      end
      ST_RD:   state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_ROOT;
      ST_ROOT: if (sts.root_done) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = sts.row_last ? ST_PICK : ST_RD;
      ST_PICK: state_nxt = sts.tree_done ? ST_OUT : ST_RD;
      ST_OUT:  if (out_free) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    res_load = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.store_pt = in_fire;
      end
      ST_INIT: cmd.init_row = 1'b1;
      ST_RD:   cmd.read_pair = 1'b1;
      ST_DIFF: cmd.take_diff = 1'b1;
      ST_SQ: begin
        cmd.take_sq = 1'b1;
        cmd.root_start = 1'b1;
      end
      ST_ROOT: cmd.root_step = 1'b1;
      ST_UPD:  cmd.update = 1'b1;
      ST_PICK: cmd.pick = 1'b1;
      ST_OUT: begin
        if (out_free) begin
          res_load = 1'b1;
          cmd.load_result = 1'b1;
          cmd.clr_set = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/emst_path.sv
`timescale 1ns / 1ps
module emst_path
  import emst_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MaxPointsDefault
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  emst_cmd_t                cmd,
  input  logic signed [CoordW-1:0] x_in,
  input  logic signed [CoordW-1:0] y_in,
  output emst_sts_t                sts,
  output logic [LenW-1:0]          total_length,
  output logic [CountW-1:0]        point_count,
  output logic                     overflow
);

  localparam int unsigned IdxW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);
  localparam logic [CntW-1:0] CapCount = CntW'(MAX_POINTS);
  localparam logic [LenW-1:0] LenMax = '1;

  // point stores, read ports registered
  logic signed [CoordW-1:0] xs_mem [MAX_POINTS];
  logic signed [CoordW-1:0] ys_mem [MAX_POINTS];
  logic [DistW-1:0] near_mem [MAX_POINTS];
  logic [MAX_POINTS-1:0] in_tree_r;

  logic [CntW-1:0] held_r;
  logic dropped_r;
  logic [IdxW-1:0] cur_r, idx_r, best_r, wr_idx;
  logic best_ok_r;
  logic [DistW-1:0] best_d_r, near_rd_r;
  logic signed [CoordW-1:0] xc_r, yc_r, xi_r, yi_r;
  logic [CoordW:0] ax_r, ay_r;
  logic [2*RootW-1:0] rad_r;
  logic [RootW+1:0] rem_r;
  logic [RootW-1:0] root_r;
  logic [5:0] bit_r;
  logic [LenW:0] total_r;
  logic [CntW-1:0] done_cnt_r;
  logic [LenW-1:0] res_len_r;

  assign wr_idx = held_r[IdxW-1:0];

  // store points
  always_ff @(posedge clk) begin
    if (cmd.store_pt && held_r < CapCount) begin
      xs_mem[wr_idx] <= x_in;
      ys_mem[wr_idx] <= y_in;
    end
  end

  // count held points, flag drops
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_set) begin
      held_r <= '0;
      dropped_r <= 1'b0;
    end else if (cmd.store_pt) begin
      if (held_r < CapCount) held_r <= held_r + 1'b1;
      else dropped_r <= 1'b1;
    end
  end

  // read the pair of points and current nearest distance
  always_ff @(posedge clk) begin
    if (cmd.read_pair) begin
      xc_r <= xs_mem[cur_r];
      yc_r <= ys_mem[cur_r];
      xi_r <= xs_mem[idx_r];
      yi_r <= ys_mem[idx_r];
      near_rd_r <= near_mem[idx_r];
    end
  end

  // absolute differences
  logic signed [CoordW:0] dx, dy;
  assign dx = {xc_r[CoordW-1], xc_r} - {xi_r[CoordW-1], xi_r};
  assign dy = {yc_r[CoordW-1], yc_r} - {yi_r[CoordW-1], yi_r};
  always_ff @(posedge clk) begin
    if (cmd.take_diff) begin
      ax_r <= dx[CoordW] ? (CoordW+1)'(-dx) : (CoordW+1)'(dx);
      ay_r <= dy[CoordW] ? (CoordW+1)'(-dy) : (CoordW+1)'(dy);
    end
  end

  // squared distance, loaded as the radicand scaled by 2^32
  logic [2*CoordW+1:0] sqx, sqy, sq_sum;
  assign sqx = ax_r * ax_r;
  assign sqy = ay_r * ay_r;
  assign sq_sum = sqx + sqy;

  // shift-and-subtract square root, one result bit per cycle
  logic [RootW+1:0] rem_sh, trial;
  assign rem_sh = {rem_r[RootW-1:0], rad_r[2*RootW-1 -: 2]};
  assign trial = {root_r, 2'b01};
  always_ff @(posedge clk) begin
    if (cmd.take_sq) rad_r <= {3'b0, D2W'(sq_sum), 32'b0};
    else if (cmd.root_step && !sts.root_done) rad_r <= rad_r << 2;
  end
  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      root_r <= '0;
      rem_r <= '0;
      bit_r <= 6'(RootW - 1);
    end else if (cmd.root_step && !sts.root_done) begin
      if (rem_sh >= trial) begin
        rem_r <= rem_sh - trial;
        root_r <= {root_r[RootW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        root_r <= {root_r[RootW-2:0], 1'b0};
      end
      bit_r <= bit_r - 1'b1;
    end
  end
  logic root_busy_r;
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.root_start) root_busy_r <= 1'b1;
    else if (cmd.root_step && bit_r == '0) root_busy_r <= 1'b0;
  end
  assign sts.root_done = !root_busy_r;

  // row update, best tracking and tree growth
  logic [DistW-1:0] new_d;
  logic skip;
  assign skip = in_tree_r[idx_r];
  assign new_d = (DistW'(root_r) < near_rd_r) ? DistW'(root_r) : near_rd_r;
  logic [LenW:0] sum;
  assign sum = total_r + (LenW+1)'(best_d_r);

  always_ff @(posedge clk) begin
    if (cmd.init_row) near_mem[idx_r] <= '1;
    else if (cmd.update && !skip) near_mem[idx_r] <= new_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_set) begin
      in_tree_r <= '0;
      idx_r <= '0;
      cur_r <= '0;
      best_ok_r <= 1'b0;
      total_r <= '0;
      done_cnt_r <= '0;
    end else if (cmd.init_row) begin
      idx_r <= sts.init_last ? '0 : idx_r + 1'b1;
      in_tree_r[0] <= 1'b1;
      done_cnt_r <= CntW'(1);
    end else if (cmd.update) begin
      if (!skip && (!best_ok_r || new_d < best_d_r)) begin
        best_ok_r <= 1'b1;
        best_r <= idx_r;
        best_d_r <= new_d;
      end
      idx_r <= sts.row_last ? '0 : idx_r + 1'b1;
    end else if (cmd.pick) begin
      in_tree_r[best_r] <= 1'b1;
      cur_r <= best_r;
      best_ok_r <= 1'b0;
      total_r <= (sum > (LenW+1)'(LenMax)) ? (LenW+1)'(LenMax) : sum;
      done_cnt_r <= done_cnt_r + 1'b1;
    end
  end

  // result
  always_ff @(posedge clk) begin
    if (cmd.load_result) res_len_r <= (held_r < CntW'(2)) ? '0 : total_r[LenW-1:0];
  end
  logic [CountW-1:0] cnt_r;
  logic ovf_r;
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      cnt_r <= CountW'(held_r);
      ovf_r <= dropped_r;
    end
  end

  assign total_length = res_len_r;
  assign point_count = cnt_r;
  assign overflow = ovf_r;

  assign sts.full = (held_r == CapCount);
  assign sts.few = (held_r < CntW'(2));
  assign sts.row_last = (CntW'(idx_r) == held_r - 1'b1);
  assign sts.init_last = (CntW'(idx_r) == held_r - 1'b1);
  assign sts.tree_done = (done_cnt_r + 1'b1 == held_r);

endmodule

// File: hw/rtl/euclidean_mst_length.sv
`timescale 1ns / 1ps
// Euclidean minimum spanning tree length. Points load one per cycle; the
// point carrying tlast starts a Prim pass over the held set and one result
// (total length in 23.16 fixed point, count, overflow) follows. For each
// candidate edge the pass steps through the read, difference, square, root
// and update states, the root state running a shift-and-subtract square
// root in the datapath. Input stalls meanwhile.
module euclidean_mst_length
  import emst_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MaxPointsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // x_coord[15:0], y_coord[31:16]
  input  logic        in_tlast,   // last_point
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // total_length[38:0], point_count[45:39],
                                  // overflow[46], zero fill
);

  emst_cmd_t cmd;
  emst_sts_t sts;
  logic in_fire, res_load, out_valid_r;
  logic [LenW-1:0] len;
  logic [CountW-1:0] cnt;
  logic ovf;

  assign in_fire = in_tvalid && in_tready;

  emst_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_last(in_tlast),
    .out_free(!out_valid_r || out_tready),
    .sts, .cmd, .in_ready(in_tready), .res_load
  );

  emst_path #(.MAX_POINTS(MAX_POINTS)) u_path (
    .clk, .rst_n, .cmd,
    .x_in(in_tdata[15:0]), .y_in(in_tdata[31:16]),
    .sts, .total_length(len), .point_count(cnt), .overflow(ovf)
  );

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (res_load) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {1'b0, ovf, cnt, len};

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || out_tready)) else $error("result overrun");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_tdata))
    else $error("result dropped while stalled");

  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !res_load) else $error("input open while loading result");

endmodule

// File: tb/sv/mst_length_checker.sv
`timescale 1ns / 1ps
module mst_length_checker #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  output int          fail_count,
  output int          lengths_pending,
  output int          lengths_seen
);

  typedef struct packed {
    logic        overflow;
    logic [6:0]  point_count;
    logic [38:0] total_length;
  } tree_result_t;

  // shadow of the point set
  int           set_x [MAX_POINTS];
  int           set_y [MAX_POINTS];
  int unsigned  set_size;
  logic         set_dropped;
  tree_result_t expected_lengths [$];

  assign lengths_pending = expected_lengths.size();

  // floor(sqrt(d2) * 2^16), decided bit by bit on exact squares
  function automatic logic [33:0] edge_root(int dx, int dy);
    logic [69:0] d2;
    logic [69:0] c;
    logic [33:0] r;
    d2 = 70'(longint'(dx) * dx + longint'(dy) * dy) << 32;
    r  = '0;
    for (int b = 33; b >= 0; b--) begin
      c = 70'(r | (34'd1 << b));
      if (c * c <= d2) r = c[33:0];
    end
    return r;
  endfunction

  // Prim pass over the held points, saturating sum
  function automatic logic [38:0] tree_total();
    longint unsigned nearest [MAX_POINTS];
    bit              joined  [MAX_POINTS];
    longint unsigned total;
    longint unsigned d;
    int              cur;
    int              best;
    total = 0;
    if (set_size < 2) return '0;
    for (int i = 0; i < set_size; i++) begin
      joined[i]  = 0;
      nearest[i] = 64'hFFFF_FFFF_FFFF_FFFF;
    end
    joined[0] = 1;
    cur = 0;
    for (int k = 1; k < set_size; k++) begin
      best = -1;
      for (int i = 0; i < set_size; i++) begin
        if (joined[i]) continue;
        d = edge_root(set_x[cur] - set_x[i], set_y[cur] - set_y[i]);
        if (d < nearest[i]) nearest[i] = d;
        if (best < 0 || nearest[i] < nearest[best]) best = i;
      end
      joined[best] = 1;
      total += nearest[best];
      if (total > 64'h7F_FFFF_FFFF) total = 64'h7F_FFFF_FFFF;
      cur = best;
    end
    return total[38:0];
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    tree_result_t res;
    tree_result_t want;
    if (!rst_n) begin
      set_size    = 0;
      set_dropped = 0;
      fail_count  = 0;
      lengths_seen = 0;
      expected_lengths.delete();
    end else begin
      // store the point, or drop it when the set is full
      if (in_tvalid && in_tready) begin
        if (set_size < MAX_POINTS) begin
          set_x[set_size] = int'($signed(in_tdata[15:0]));
          set_y[set_size] = int'($signed(in_tdata[31:16]));
          set_size++;
        end else begin
          set_dropped = 1;
        end
        if (in_tlast) begin
          res.total_length = tree_total();
          res.point_count  = 7'(set_size);
          res.overflow     = set_dropped;
          expected_lengths.push_back(res);
          set_size    = 0;
          set_dropped = 0;
        end
      end
      // compare each result transaction with the oldest expectation
      if (out_tvalid && out_tready) begin
        lengths_seen++;
        res = out_tdata[46:0];
        if (expected_lengths.size() == 0) begin
          report_mismatch("unexpected result transaction", 1, 0);
        end else begin
          want = expected_lengths.pop_front();
          if (res.total_length != want.total_length)
            report_mismatch("total_length", res.total_length, want.total_length);
          if (res.point_count != want.point_count)
            report_mismatch("point_count", res.point_count, want.point_count);
          if (res.overflow != want.overflow)
            report_mismatch("overflow", res.overflow, want.overflow);
        end
      end
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import emst_pkg::*;

  logic        clk = 0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  int          fail_count;
  int          lengths_pending;
  int          lengths_seen;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          points_sent;
  int          sets_sent;

  always #1 clk = ~clk;

  euclidean_mst_length uut (.*);

  mst_length_checker #(.MAX_POINTS(MaxPointsDefault)) check (.*);

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_point(logic [15:0] x, logic [15:0] y, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {y, x};
    in_tlast  <= last;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    points_sent++;
    if (last) sets_sent++;
  endtask

  // hold off until every expected length has come out, then let the block settle
  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (lengths_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // random set: mostly small, coordinates spread wide or clustered
  task automatic send_set(int n);
    bit clustered;
    clustered = $urandom_range(1);
    for (int i = 0; i < n; i++) begin
      if (clustered)
        send_point(16'($urandom_range(15) - 8), 16'($urandom_range(15) - 8), i == n - 1);
      else
        send_point(16'($urandom), 16'($urandom), i == n - 1);
    end
  endtask

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n         = 0;
    in_tvalid     = 0;
    in_tdata      = '0;
    in_tlast      = 0;
    out_tready    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    points_sent   = 0;
    sets_sent     = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // single point, then extreme corners
    send_point(16'h8000, 16'h7FFF, 1);
    send_point(16'h8000, 16'h8000, 0);
    send_point(16'h7FFF, 16'h7FFF, 1);
    send_point(16'h7FFF, 16'h8000, 0);
    send_point(16'h8000, 16'h7FFF, 0);
    send_point(16'h0000, 16'h0000, 0);
    send_point(16'hFFFF, 16'hFFFF, 1);
    // coincident points give zero length
    send_point(16'h1234, 16'hEDCB, 0);
    send_point(16'h1234, 16'hEDCB, 1);
    // non-square distance
    send_point(16'h0000, 16'h0000, 0);
    send_point(16'h0001, 16'h0001, 0);
    send_point(16'h0003, 16'hFFFE, 1);
    drain();

    // full store, then overflow with the last point dropped too
    for (int i = 0; i < 64; i++)
      send_point(16'($urandom), 16'($urandom), i == 63);
    for (int i = 0; i < 67; i++)
      send_point(16'($urandom), 16'($urandom), i == 66);
    drain();

    // random sets under each idling phase
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 85 : (phase == 3) ? 21 : 0;
      recv_idle_pct = (phase == 2) ? 85 : (phase == 3) ? 21 : 0;
      while (points_sent < 115 * (phase + 1) + 143) begin
        if ($urandom_range(9) == 0) send_point(16'($urandom), 16'($urandom), 0);
        send_set($urandom_range(1, 8));
      end
      if (phase == 1) drain();
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();

    $display("Sent %0d points in %0d sets, %0d tree lengths checked", points_sent, sets_sent,
             lengths_seen);
    $display("Covered single, coincident, corner, full and overflowing sets under stalls");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/emst_pkg.sv
hw/rtl/emst_ctrl.sv
hw/rtl/emst_path.sv
hw/rtl/euclidean_mst_length.sv
tb/sv/mst_length_checker.sv
tb/sv/testbench.sv
